@@ rtl/windowed_sample_history_table_top_macros.svh @@
// Assertion macros shared by the checker of the sample history table.
// Depends on nothing; clk_i and rst_ni must be visible where a macro is used.
`ifndef WINDOWED_SAMPLE_HISTORY_TABLE_TOP_MACROS_SVH
`define WINDOWED_SAMPLE_HISTORY_TABLE_TOP_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define WSHT_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("sample history table check failed");

// The consequent must hold in the cycle after the antecedent.
`define WSHT_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("sample history table check failed");

`endif

@@ rtl/wsht_pkg.sv @@
// Types and constants of the windowed sample history table.
// Used by the controller, the datapath, the top level and the checker.
package wsht_pkg;

  // Result status codes.
  typedef enum logic [2:0] {
    ST_APPEND = 3'd0,
    ST_INSERT = 3'd1,
    ST_REJECT = 3'd2,
    ST_DUP    = 3'd3,
    ST_READ   = 3'd4
  } status_e;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    CFG_BUCKET  = 2'd0,
    CFG_WINDOW  = 2'd1,
    CFG_PERSIST = 2'd2,
    CFG_MAX     = 2'd3
  } cfg_idx_e;

  // Input operation codes.
  localparam logic OP_RECORD = 1'b0;
  localparam logic OP_READ   = 1'b1;

  // Configuration reset values.
  localparam logic [21:0] BUCKET_RST  = 22'd300000;
  localparam logic [29:0] WINDOW_RST  = 30'd86400000;
  localparam logic [26:0] PERSIST_RST = 27'd1800000;
  localparam logic [9:0]  MAX_RST     = 10'd289;

  // Valid reading ranges.
  localparam logic [15:0]        CO2_MIN  = 16'd250;
  localparam logic [15:0]        CO2_MAX  = 16'd10000;
  localparam logic signed [11:0] TEMP_MIN = -12'sd640;
  localparam logic signed [11:0] TEMP_MAX = 12'sd1360;
  localparam logic [10:0]        HUM_MAX  = 11'd1600;

  // Stored entry: time above humidity, temperature and CO2.
  localparam int unsigned ENTRY_W = 85;

  // Controller states.
  typedef enum logic [3:0] {
    S_IDLE, S_DIV, S_DIV_WAIT, S_CHECK, S_SCAN, S_SHIFT_GO, S_SHIFT,
    S_INSERT, S_EVICT_GO, S_EVICT, S_READ, S_DONE
  } state_e;

  // Datapath operations.
  typedef enum logic [3:0] {
    OPC_NOP, OPC_LOAD, OPC_DIV_GO, OPC_BUCKET, OPC_REJECT, OPC_SCAN_INIT,
    OPC_SCAN_STEP, OPC_SCAN_END, OPC_SHIFT_INIT, OPC_SHIFT_STEP, OPC_INSERT,
    OPC_EVICT_INIT, OPC_EVICT_STEP, OPC_TRIM, OPC_READ, OPC_EMIT
  } cmd_op_e;

  typedef struct packed {
    cmd_op_e op;
    logic    rd_en;
  } cmd_t;

  typedef struct packed {
    logic div_done;
    logic rec_ok;
    logic scan_stop;
    logic dup;
    logic shift_skip;
    logic shift_last;
    logic evict_stop;
    logic out_busy;
  } sts_t;

endpackage

@@ rtl/wsht_div.sv @@
// Bit-serial remainder unit: dividend modulo divisor, one bit per cycle.
// Standalone.
module wsht_div (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [47:0] dividend_i,
  input  logic [21:0] divisor_i,
  output logic        done_o,
  output logic [21:0] rem_o
);
  logic        busy_q, busy_d, done_q, done_d;
  logic [5:0]  cnt_q, cnt_d;
  logic [47:0] dvd_q, dvd_d;
  logic [21:0] rem_q, rem_d;
  logic [22:0] trial;
  logic [22:0] diff;

  // One restoring step per cycle.
  always_comb begin
    trial  = {rem_q, dvd_q[47]};
    diff   = trial - {1'b0, divisor_i};
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    dvd_d  = dvd_q;
    rem_d  = rem_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = 6'd0;
      dvd_d  = dividend_i;
      rem_d  = 22'd0;
    end else if (busy_q) begin
      rem_d = (trial >= {1'b0, divisor_i}) ? diff[21:0] : trial[21:0];
      dvd_d = {dvd_q[46:0], 1'b0};
      cnt_d = cnt_q + 6'd1;
      if (cnt_q == 6'd47) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= 6'd0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    rem_q <= rem_d;
  end

  assign done_o = done_q;
  assign rem_o  = rem_q;
endmodule

@@ rtl/wsht_ctrl.sv @@
// Controller of the sample history table: sequences division, search, shift,
// eviction and reads. Depends on wsht_pkg.
module wsht_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  input  logic          opcode_i,
  output logic          in_ready_o,
  input  wsht_pkg::sts_t sts_i,
  output wsht_pkg::cmd_t cmd_o
);
  import wsht_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and commands.
  always_comb begin
    state_d     = state_q;
    cmd_o.op    = OPC_NOP;
    cmd_o.rd_en = 1'b0;
    in_ready_o  = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.op = OPC_LOAD;
          state_d  = (opcode_i == OP_READ) ? S_READ : S_DIV;
        end
      end
      S_DIV: begin
        cmd_o.op = OPC_DIV_GO;
        state_d  = S_DIV_WAIT;
      end
      S_DIV_WAIT: begin
        if (sts_i.div_done) begin
          cmd_o.op = OPC_BUCKET;
          state_d  = S_CHECK;
        end
      end
      S_CHECK: begin
        if (sts_i.rec_ok) begin
          cmd_o.op    = OPC_SCAN_INIT;
          cmd_o.rd_en = 1'b1;
          state_d     = S_SCAN;
        end else begin
          cmd_o.op = OPC_REJECT;
          state_d  = S_DONE;
        end
      end
      S_SCAN: begin
        if (!sts_i.scan_stop) begin
          cmd_o.op    = OPC_SCAN_STEP;
          cmd_o.rd_en = 1'b1;
        end else begin
          cmd_o.op = OPC_SCAN_END;
          state_d  = sts_i.dup ? S_DONE : S_SHIFT_GO;
        end
      end
      S_SHIFT_GO: begin
        if (sts_i.shift_skip) begin
          state_d = S_INSERT;
        end else begin
          cmd_o.op    = OPC_SHIFT_INIT;
          cmd_o.rd_en = 1'b1;
          state_d     = S_SHIFT;
        end
      end
      S_SHIFT: begin
        cmd_o.op    = OPC_SHIFT_STEP;
        cmd_o.rd_en = !sts_i.shift_last;
        if (sts_i.shift_last) begin
          state_d = S_INSERT;
        end
      end
      S_INSERT: begin
        cmd_o.op = OPC_INSERT;
        state_d  = S_EVICT_GO;
      end
      S_EVICT_GO: begin
        cmd_o.op    = OPC_EVICT_INIT;
        cmd_o.rd_en = 1'b1;
        state_d     = S_EVICT;
      end
      S_EVICT: begin
        if (!sts_i.evict_stop) begin
          cmd_o.op    = OPC_EVICT_STEP;
          cmd_o.rd_en = 1'b1;
        end else begin
          cmd_o.op = OPC_TRIM;
          state_d  = S_DONE;
        end
      end
      S_READ: begin
        cmd_o.op    = OPC_READ;
        cmd_o.rd_en = 1'b1;
        state_d     = S_DONE;
      end
      S_DONE: begin
        if (!sts_i.out_busy) begin
          cmd_o.op = OPC_EMIT;
          state_d  = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end
endmodule

@@ rtl/wsht_dp.sv @@
// Datapath of the sample history table: configuration, circular entry memory,
// counters, checks and the result register. Depends on wsht_pkg and wsht_div.
module wsht_dp #(
  parameter int CAPACITY = 512
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cfg_we_i,
  input  logic [1:0]    cfg_index_i,
  input  logic [29:0]   cfg_data_i,
  input  logic          opcode_i,
  input  logic [47:0]   observed_time_i,
  input  logic [47:0]   current_time_i,
  input  logic          sensor_connected_i,
  input  logic [15:0]   co2_ppm_i,
  input  logic signed [11:0] temperature_q4_i,
  input  logic [10:0]   humidity_q4_i,
  input  logic [8:0]    read_index_i,
  input  wsht_pkg::cmd_t cmd_i,
  output wsht_pkg::sts_t sts_o,
  input  logic          out_ready_i,
  output logic          out_valid_o,
  output logic [2:0]    status_o,
  output logic [9:0]    evicted_count_o,
  output logic [9:0]    entry_count_o,
  output logic          save_due_o,
  output logic [47:0]   entry_time_o,
  output logic [13:0]   entry_co2_o,
  output logic signed [11:0] entry_temperature_o,
  output logic [10:0]   entry_humidity_o
);
  import wsht_pkg::*;

  localparam int AW   = $clog2(CAPACITY + 1);
  localparam int PHYS = 2 ** AW;
  localparam int CW   = $clog2(CAPACITY + 2);
  localparam int RW   = (CW > 9) ? CW : 9;
  localparam int OW   = (CW > 10) ? CW : 10;

  // Configuration registers.
  logic [21:0] bucket_len_q;
  logic [29:0] window_len_q;
  logic [26:0] persist_q;
  logic [9:0]  max_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bucket_len_q <= BUCKET_RST;
      window_len_q <= WINDOW_RST;
      persist_q    <= PERSIST_RST;
      max_q        <= MAX_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_BUCKET:  bucket_len_q <= cfg_data_i[21:0];
        CFG_WINDOW:  window_len_q <= cfg_data_i;
        CFG_PERSIST: persist_q    <= cfg_data_i[26:0];
        CFG_MAX:     max_q        <= cfg_data_i[9:0];
        default:     max_q        <= max_q;
      endcase
    end
  end

  // Latched item fields.
  logic        opcode_q;
  logic [47:0] obs_q, now_q;
  logic        conn_q;
  logic [15:0] co2_q;
  logic signed [11:0] temp_q;
  logic [10:0] hum_q;
  logic [8:0]  ridx_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.op == OPC_LOAD) begin
      opcode_q <= opcode_i;
      obs_q    <= observed_time_i;
      now_q    <= current_time_i;
      conn_q   <= sensor_connected_i;
      co2_q    <= co2_ppm_i;
      temp_q   <= temperature_q4_i;
      hum_q    <= humidity_q4_i;
      ridx_q   <= read_index_i;
    end
  end

  // Bucket rounding through the serial remainder unit.
  logic [21:0] blen_eff;
  logic        div_done;
  logic [21:0] div_rem;
  logic [47:0] bucket_q;

  assign blen_eff = (bucket_len_q == 22'd0) ? 22'd1 : bucket_len_q;

  wsht_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.op == OPC_DIV_GO),
    .dividend_i (obs_q),
    .divisor_i  (blen_eff),
    .done_o     (div_done),
    .rem_o      (div_rem)
  );

  always_ff @(posedge clk_i) begin
    if (cmd_i.op == OPC_BUCKET) begin
      bucket_q <= obs_q - {26'd0, div_rem};
    end
  end

  // Record validity.
  logic rec_ok;
  always_comb begin
    rec_ok = conn_q && (obs_q != 48'd0) &&
             ({1'b0, obs_q} <= {1'b0, now_q} + {27'd0, blen_eff}) &&
             !({1'b0, bucket_q} + {19'd0, window_len_q} < {1'b0, now_q}) &&
             (co2_q >= CO2_MIN) && (co2_q <= CO2_MAX) &&
             (temp_q >= TEMP_MIN) && (temp_q <= TEMP_MAX) &&
             (hum_q <= HUM_MAX);
  end

  // Table state: circular buffer with head pointer.
  logic [AW-1:0] head_q;
  logic [CW-1:0] count_q, n_q, idx_q, pos_q, evict_q;
  logic [47:0]   last_save_q;
  logic          save_q;
  status_e       status_q;

  // Entry memory.
  logic [ENTRY_W-1:0] mem_q [PHYS];
  logic [ENTRY_W-1:0] rdata_q, wdata;
  logic [CW-1:0]      rd_log, wr_log;
  logic [AW-1:0]      raddr, waddr;
  logic               we;
  logic [47:0]        rtime;

  assign rtime = rdata_q[ENTRY_W-1 -: 48];

  // Logical read and write indexes per operation.
  always_comb begin
    rd_log = idx_q;
    wr_log = pos_q;
    we     = 1'b0;
    wdata  = rdata_q;
    unique case (cmd_i.op)
      OPC_SCAN_INIT, OPC_EVICT_INIT: rd_log = '0;
      OPC_SCAN_STEP, OPC_EVICT_STEP: rd_log = idx_q + CW'(1);
      OPC_SHIFT_INIT:                rd_log = n_q - CW'(1);
      OPC_SHIFT_STEP: begin
        rd_log = idx_q - CW'(1);
        wr_log = idx_q + CW'(1);
        we     = 1'b1;
      end
      OPC_INSERT: begin
        we    = 1'b1;
        wdata = {bucket_q, hum_q, temp_q, co2_q[13:0]};
      end
      OPC_READ: rd_log = CW'(ridx_q);
      default:  rd_log = idx_q;
    endcase
  end

  assign raddr = head_q + rd_log[AW-1:0];
  assign waddr = head_q + wr_log[AW-1:0];

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_q[waddr] <= wdata;
    end
    if (cmd_i.rd_en) begin
      rdata_q <= mem_q[raddr];
    end
  end

  // Effective maximum count and trimming.
  logic [OW-1:0] max_w;
  logic [CW-1:0] mx, rem_cnt, k_final;
  logic          read_ok;
  logic          save_now;

  always_comb begin
    max_w = OW'(max_q);
    if (max_w == '0) begin
      max_w = OW'(1);
    end else if (max_w > OW'(CAPACITY)) begin
      max_w = OW'(CAPACITY);
    end
    mx      = max_w[CW-1:0];
    rem_cnt = n_q - idx_q;
    k_final = (rem_cnt > mx) ? (n_q - mx) : idx_q;
    read_ok = (RW'(ridx_q) < RW'(count_q)) && (RW'(ridx_q) < RW'(CAPACITY));
    save_now = (last_save_q == 48'd0) ||
               ({1'b0, now_q} >= {1'b0, last_save_q} + {22'd0, persist_q});
  end

  // Control and status registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q      <= '0;
      count_q     <= '0;
      last_save_q <= 48'd0;
      n_q         <= '0;
      idx_q       <= '0;
      pos_q       <= '0;
      evict_q     <= '0;
      save_q      <= 1'b0;
      status_q    <= ST_REJECT;
    end else begin
      unique case (cmd_i.op)
        OPC_LOAD: begin
          evict_q <= '0;
          save_q  <= 1'b0;
        end
        OPC_REJECT: status_q <= ST_REJECT;
        OPC_SCAN_INIT: begin
          n_q   <= count_q;
          idx_q <= '0;
        end
        OPC_SCAN_STEP, OPC_EVICT_STEP: idx_q <= idx_q + CW'(1);
        OPC_SCAN_END: begin
          pos_q <= idx_q;
          if (sts_o.dup) begin
            status_q <= ST_DUP;
          end else if (idx_q == n_q) begin
            status_q <= ST_APPEND;
          end else begin
            status_q <= ST_INSERT;
          end
        end
        OPC_SHIFT_INIT: idx_q <= n_q - CW'(1);
        OPC_SHIFT_STEP: idx_q <= idx_q - CW'(1);
        OPC_INSERT:     n_q   <= n_q + CW'(1);
        OPC_EVICT_INIT: idx_q <= '0;
        OPC_TRIM: begin
          head_q  <= head_q + k_final[AW-1:0];
          count_q <= n_q - k_final;
          evict_q <= k_final;
          if (save_now) begin
            save_q      <= 1'b1;
            last_save_q <= now_q;
          end
        end
        OPC_READ: status_q <= read_ok ? ST_READ : ST_REJECT;
        default: status_q <= status_q;
      endcase
    end
  end

  // Status toward the controller.
  always_comb begin
    sts_o.div_done   = div_done;
    sts_o.rec_ok     = rec_ok;
    sts_o.scan_stop  = (idx_q == n_q) || (rtime >= bucket_q);
    sts_o.dup        = (idx_q != n_q) && (rtime == bucket_q);
    sts_o.shift_skip = (pos_q == n_q);
    sts_o.shift_last = (idx_q == pos_q);
    sts_o.evict_stop = (idx_q == n_q) ||
                       !({1'b0, rtime} + {19'd0, window_len_q} < {1'b0, now_q});
    sts_o.out_busy   = out_valid_o && !out_ready_i;
  end

  // Result register.
  logic [OW-1:0] ev_w, cnt_w;
  logic          is_read_ok;
  assign ev_w       = OW'(evict_q);
  assign cnt_w      = OW'(count_q);
  assign is_read_ok = (status_q == ST_READ) && (opcode_q == OP_READ);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (cmd_i.op == OPC_EMIT) begin
      out_valid_o <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_o <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.op == OPC_EMIT) begin
      status_o            <= status_q;
      evicted_count_o     <= ev_w[9:0];
      entry_count_o       <= cnt_w[9:0];
      save_due_o          <= save_q;
      entry_time_o        <= is_read_ok ? rtime : 48'd0;
      entry_co2_o         <= is_read_ok ? rdata_q[13:0] : 14'd0;
      entry_temperature_o <= is_read_ok ? rdata_q[25:14] : 12'sd0;
      entry_humidity_o    <= is_read_ok ? rdata_q[36:26] : 11'd0;
    end
  end
endmodule

@@ rtl/windowed_sample_history_table_top.sv @@
// Top level of the windowed sample history table.
// Depends on wsht_pkg, wsht_ctrl and wsht_dp (which holds wsht_div).
//
// Channel   Signals                              Direction
// input     in_valid_i / in_ready_o + fields     into block
// output    out_valid_o / out_ready_i + fields   out of block
// config    cfg_we_i, cfg_index_i, cfg_data_i    into block, write only
//
// One item at a time. A read passes through the read and done states, and the block
// is ready for the next item once its result is registered.
// A rejected record waits for the serial bucket remainder, then fails the checks.
// A stored record also searches the held entries in order, moves later entries up,
// writes the new entry and then checks the oldest entries for age and the limit.
// Reset clears the count, head pointer and save time; entry memory is not cleared.
// A stalled result holds in the output register; the block then waits before
// emitting the next result.
module windowed_sample_history_table_top #(
  parameter int CAPACITY = 512
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [29:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        opcode_i,
  input  logic [47:0] observed_time_i,
  input  logic [47:0] current_time_i,
  input  logic        sensor_connected_i,
  input  logic [15:0] co2_ppm_i,
  input  logic signed [11:0] temperature_q4_i,
  input  logic [10:0] humidity_q4_i,
  input  logic [8:0]  read_index_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [2:0]  status_o,
  output logic [9:0]  evicted_count_o,
  output logic [9:0]  entry_count_o,
  output logic        save_due_o,
  output logic [47:0] entry_time_o,
  output logic [13:0] entry_co2_o,
  output logic signed [11:0] entry_temperature_o,
  output logic [10:0] entry_humidity_o
);
  import wsht_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // Sequencer.
  wsht_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .opcode_i   (opcode_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // Table storage and arithmetic.
  wsht_dp #(.CAPACITY(CAPACITY)) u_dp (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cfg_we_i            (cfg_we_i),
    .cfg_index_i         (cfg_index_i),
    .cfg_data_i          (cfg_data_i),
    .opcode_i            (opcode_i),
    .observed_time_i     (observed_time_i),
    .current_time_i      (current_time_i),
    .sensor_connected_i  (sensor_connected_i),
    .co2_ppm_i           (co2_ppm_i),
    .temperature_q4_i    (temperature_q4_i),
    .humidity_q4_i       (humidity_q4_i),
    .read_index_i        (read_index_i),
    .cmd_i               (cmd),
    .sts_o               (sts),
    .out_ready_i         (out_ready_i),
    .out_valid_o         (out_valid_o),
    .status_o            (status_o),
    .evicted_count_o     (evicted_count_o),
    .entry_count_o       (entry_count_o),
    .save_due_o          (save_due_o),
    .entry_time_o        (entry_time_o),
    .entry_co2_o         (entry_co2_o),
    .entry_temperature_o (entry_temperature_o),
    .entry_humidity_o    (entry_humidity_o)
  );
endmodule

@@ rtl/wsht_checker.sv @@
// Port-level checks of the sample history table, bound to the top level.
// Depends on wsht_pkg and windowed_sample_history_table_top_macros.svh.
`include "windowed_sample_history_table_top_macros.svh"

module wsht_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_o,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [2:0]  status_o,
  input logic [9:0]  evicted_count_o,
  input logic        save_due_o,
  input logic [47:0] entry_time_o
);
  import wsht_pkg::*;

  logic ev_or_save;
  logic rec_stored;

  assign ev_or_save = out_valid_o && (evicted_count_o != 10'd0 || save_due_o);
  assign rec_stored = (status_o == ST_APPEND) || (status_o == ST_INSERT);

  // A result waits until it is taken.
  `WSHT_ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o)

  // Only an appended or inserted record evicts or raises a save.
  `WSHT_ASSERT_SAME(a_evict_rec, ev_or_save, rec_stored)

  // The entry time is zero unless a read succeeded.
  `WSHT_ASSERT_SAME(a_entry_zero, out_valid_o && status_o != ST_READ, entry_time_o == 48'd0)

  // An item is never taken in the cycle right after another.
  `WSHT_ASSERT_NEXT(a_one_at_a_time, in_valid_i && in_ready_o, !in_ready_o)
endmodule

bind windowed_sample_history_table_top wsht_checker u_wsht_checker (.*);

@@ bench/windowed_sample_history_table_top_checker.sv @@
// Checker of the windowed sample history table: watches the configuration port
// and both item channels, predicts each result and compares it. Depends on wsht_pkg.
module windowed_sample_history_table_top_checker #(
  parameter int CAPACITY = 512
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_index_i,
  input  logic [29:0]        cfg_data_i,
  input  logic               in_valid_i,
  input  logic               in_ready_i,
  input  logic               opcode_i,
  input  logic [47:0]        observed_time_i,
  input  logic [47:0]        current_time_i,
  input  logic               sensor_connected_i,
  input  logic [15:0]        co2_ppm_i,
  input  logic signed [11:0] temperature_q4_i,
  input  logic [10:0]        humidity_q4_i,
  input  logic [8:0]         read_index_i,
  input  logic               out_valid_i,
  input  logic               out_ready_i,
  input  logic [2:0]         status_i,
  input  logic [9:0]         evicted_count_i,
  input  logic [9:0]         entry_count_i,
  input  logic               save_due_i,
  input  logic [47:0]        entry_time_i,
  input  logic [13:0]        entry_co2_i,
  input  logic signed [11:0] entry_temperature_i,
  input  logic [10:0]        entry_humidity_i,
  output int                 fail_count_o,
  output int                 pending_count_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import wsht_pkg::*;

  typedef struct {
    logic [2:0]         status;
    logic [9:0]         evicted;
    logic [9:0]         held;
    logic               save;
    logic [47:0]        etime;
    logic [13:0]        eco2;
    logic signed [11:0] etemp;
    logic [10:0]        ehum;
  } table_result_t;

  // Shadow copy of the configuration and of the sorted table.
  logic [21:0] bucket_len;
  logic [29:0] window_len;
  logic [26:0] persist_len;
  logic [9:0]  max_len;
  logic [47:0]        hist_time [0:CAPACITY];
  logic [13:0]        hist_co2  [0:CAPACITY];
  logic signed [11:0] hist_temp [0:CAPACITY];
  logic [10:0]        hist_hum  [0:CAPACITY];
  int          hist_count;
  longint      last_save;
  table_result_t expected_results[$];
  int          fails;

  assign fail_count_o    = fails;
  assign pending_count_o = expected_results.size();

  // Apply one item to the shadow table and return the result it should give.
  function automatic table_result_t predict_table_step();
    table_result_t r;
    longint now, cutoff, obs, blen, bkt;
    int n, pos, k, rem, mx;
    bit dup;
    r = '{status: ST_REJECT, evicted: '0, held: '0, save: 1'b0, etime: '0,
          eco2: '0, etemp: '0, ehum: '0};
    if (opcode_i == OP_READ) begin
      if (int'(read_index_i) < hist_count) begin
        r.status = ST_READ;
        r.etime  = hist_time[read_index_i];
        r.eco2   = hist_co2[read_index_i];
        r.etemp  = hist_temp[read_index_i];
        r.ehum   = hist_hum[read_index_i];
      end
    end else begin
      obs    = longint'({16'd0, observed_time_i});
      now    = longint'({16'd0, current_time_i});
      blen   = (bucket_len == 0) ? 1 : longint'(bucket_len);
      bkt    = (obs / blen) * blen;
      cutoff = now - longint'(window_len);
      if (!sensor_connected_i || obs == 0 || obs > now + blen || bkt < cutoff ||
          co2_ppm_i < CO2_MIN || co2_ppm_i > CO2_MAX || temperature_q4_i < TEMP_MIN ||
          temperature_q4_i > TEMP_MAX || humidity_q4_i > HUM_MAX) begin
        r.status = ST_REJECT;
      end else begin
        // Find the slot: append after the newest or search for the first bucket at or after it.
        n   = hist_count;
        pos = 0;
        dup = 0;
        if (n == 0 || longint'({16'd0, hist_time[n-1]}) < bkt) begin
          pos      = n;
          r.status = ST_APPEND;
        end else begin
          while (pos < n && longint'({16'd0, hist_time[pos]}) < bkt) pos++;
          dup      = (pos < n && longint'({16'd0, hist_time[pos]}) == bkt);
          r.status = dup ? ST_DUP : ST_INSERT;
        end
        if (!dup) begin
          for (int i = n; i > pos; i--) begin
            hist_time[i] = hist_time[i-1];
            hist_co2[i]  = hist_co2[i-1];
            hist_temp[i] = hist_temp[i-1];
            hist_hum[i]  = hist_hum[i-1];
          end
          hist_time[pos] = bkt[47:0];
          hist_co2[pos]  = co2_ppm_i[13:0];
          hist_temp[pos] = temperature_q4_i;
          hist_hum[pos]  = humidity_q4_i;
          n++;
          // Drop entries past the window, then the oldest beyond the limit.
          mx = (max_len == 0) ? 1 : (int'(max_len) > CAPACITY ? CAPACITY : int'(max_len));
          k  = 0;
          while (k < n && longint'({16'd0, hist_time[k]}) < cutoff) k++;
          rem = n - k;
          if (rem > mx) k += rem - mx;
          for (int i = 0; i < n - k; i++) begin
            hist_time[i] = hist_time[i+k];
            hist_co2[i]  = hist_co2[i+k];
            hist_temp[i] = hist_temp[i+k];
            hist_hum[i]  = hist_hum[i+k];
          end
          hist_count = n - k;
          r.evicted  = k[9:0];
          if (last_save == 0 || now - last_save >= longint'(persist_len)) begin
            r.save    = 1'b1;
            last_save = now;
          end
        end
      end
    end
    r.held = hist_count[9:0];
    return r;
  endfunction

  // Report one field that differs from its expectation.
  task automatic check_field(string name, longint exp_v, longint act_v);
    if (exp_v != act_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, act_v);
      fails++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    table_result_t e;
    if (!rst_ni) begin
      bucket_len  <= BUCKET_RST;
      window_len  <= WINDOW_RST;
      persist_len <= PERSIST_RST;
      max_len     <= MAX_RST;
      hist_count  = 0;
      last_save   = 0;
      expected_results.delete();
    end else begin
      // Compare a delivered result with the oldest expectation.
      if (out_valid_i && out_ready_i) begin
        if (expected_results.size() == 0) begin
          $error("result item with no expectation waiting");
          fails++;
        end else begin
          e = expected_results.pop_front();
          check_field("status", e.status, status_i);
          check_field("evicted_count", e.evicted, evicted_count_i);
          check_field("entry_count", e.held, entry_count_i);
          check_field("save_due", e.save, save_due_i);
          check_field("entry_time", e.etime, entry_time_i);
          check_field("entry_co2", e.eco2, entry_co2_i);
          check_field("entry_temperature", e.etemp, entry_temperature_i);
          check_field("entry_humidity", e.ehum, entry_humidity_i);
        end
      end
      if (in_valid_i && in_ready_i) begin
        expected_results = {expected_results, predict_table_step()};
      end
      if (cfg_we_i) begin
        case (cfg_idx_e'(cfg_index_i))
          CFG_BUCKET:  bucket_len  <= cfg_data_i[21:0];
          CFG_WINDOW:  window_len  <= cfg_data_i[29:0];
          CFG_PERSIST: persist_len <= cfg_data_i[26:0];
          CFG_MAX:     max_len     <= cfg_data_i[9:0];
          default: ;
        endcase
      end
    end
  end

  initial fails = 0;

endmodule

@@ bench/windowed_sample_history_table_top_tb.sv @@
// Top of the sample history table testbench: clock, reset, configuration phases,
// record and read stimulus and the verdict. Depends on wsht_pkg, the block and its checker.
module windowed_sample_history_table_top_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import wsht_pkg::*;

  localparam longint CYCLE_LIMIT = 6000000;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               cfg_we_i = 1'b0;
  logic [1:0]         cfg_index_i = CFG_BUCKET;
  logic [29:0]        cfg_data_i = '0;
  logic               in_valid_i = 1'b0;
  logic               in_ready_o;
  logic               opcode_i = OP_RECORD;
  logic [47:0]        observed_time_i = '0;
  logic [47:0]        current_time_i = '0;
  logic               sensor_connected_i = 1'b0;
  logic [15:0]        co2_ppm_i = '0;
  logic signed [11:0] temperature_q4_i = '0;
  logic [10:0]        humidity_q4_i = '0;
  logic [8:0]         read_index_i = '0;
  logic               out_valid_o;
  logic               out_ready_i = 1'b0;
  logic [2:0]         status_o;
  logic [9:0]         evicted_count_o;
  logic [9:0]         entry_count_o;
  logic               save_due_o;
  logic [47:0]        entry_time_o;
  logic [13:0]        entry_co2_o;
  logic signed [11:0] entry_temperature_o;
  logic [10:0]        entry_humidity_o;
  int                 fail_count;
  int                 pending_count;

  // Host-side view of the timeline and of the bucket setting.
  longint now_ms;
  longint last_obs;
  longint bucket_ms;
  bit     idling_on;
  int     stall_left;
  longint cycle_count;

  windowed_sample_history_table_top u_dut (.*);

  windowed_sample_history_table_top_checker u_checker (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_index_i, .cfg_data_i,
    .in_valid_i, .in_ready_i(in_ready_o), .opcode_i, .observed_time_i,
    .current_time_i, .sensor_connected_i, .co2_ppm_i, .temperature_q4_i,
    .humidity_q4_i, .read_index_i, .out_valid_i(out_valid_o), .out_ready_i,
    .status_i(status_o), .evicted_count_i(evicted_count_o),
    .entry_count_i(entry_count_o), .save_due_i(save_due_o),
    .entry_time_i(entry_time_o), .entry_co2_i(entry_co2_o),
    .entry_temperature_i(entry_temperature_o), .entry_humidity_i(entry_humidity_o),
    .fail_count_o(fail_count), .pending_count_o(pending_count)
  );

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  // Result side stalls in random bursts while idling is on.
  always @(posedge clk_i) begin
    if (!idling_on) begin
      out_ready_i <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left  <= stall_left - 1;
      out_ready_i <= 1'b0;
    end else if ($urandom_range(0, 7) == 0) begin
      stall_left  <= $urandom_range(1, 15) - 1;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  // Give up if the block stops answering.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("windowed_sample_history_table_top_tb NOT OK");
      $finish;
    end
  end

  // Offer one item and wait until it is accepted.
  task automatic send_item(logic op, longint obs, longint cur, logic conn,
                           logic [15:0] co2, logic signed [11:0] temp,
                           logic [10:0] hum, logic [8:0] idx);
    if (idling_on && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk_i);
    end
    opcode_i           <= op;
    observed_time_i    <= obs[47:0];
    current_time_i     <= cur[47:0];
    sensor_connected_i <= conn;
    co2_ppm_i          <= co2;
    temperature_q4_i   <= temp;
    humidity_q4_i      <= hum;
    read_index_i       <= idx;
    in_valid_i         <= 1'b1;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
  endtask

  // Register writes happen only once every result has come back.
  task automatic write_reg(cfg_idx_e idx, logic [29:0] value);
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_count != 0) @(posedge clk_i);
    repeat (5) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == CFG_BUCKET) bucket_ms = (value[21:0] == 0) ? 1 : longint'(value[21:0]);
  endtask

  task automatic good_record(longint obs);
    send_item(OP_RECORD, obs, now_ms, 1'b1, 16'($urandom_range(250, 10000)),
              12'($signed($urandom_range(0, 2000)) - 640), 11'($urandom_range(0, 1600)), '0);
  endtask

  // Mostly well-formed records around the present time, with reads, duplicates,
  // broken records and raw noise mixed in.
  task automatic mixed_items(int count);
    int pick;
    longint obs;
    logic [15:0] co2;
    logic signed [11:0] temp;
    logic [10:0] hum;
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 45) begin
        now_ms += $urandom_range(0, 32'(bucket_ms));
        obs = now_ms - bucket_ms * $urandom_range(0, 20)
              - $urandom_range(0, 32'(bucket_ms) - 1);
        if ($urandom_range(0, 9) == 0) obs = now_ms + $urandom_range(0, 32'(bucket_ms) + 1);
        if (obs < 1) obs = 1;
        last_obs = obs;
        good_record(obs);
      end else if (pick < 55) begin
        good_record(last_obs);
      end else if (pick < 80) begin
        send_item(OP_READ, 0, now_ms, 1'b0, '0, '0, '0,
                  ($urandom_range(0, 3) == 0) ? 9'($urandom) : 9'($urandom_range(0, 40)));
      end else if (pick < 90) begin
        co2  = 16'($urandom_range(250, 10000));
        temp = 12'sd100;
        hum  = 11'd500;
        case ($urandom_range(0, 3))
          0: co2  = $urandom_range(0, 1) ? 16'd249 : 16'd10001;
          1: temp = $urandom_range(0, 1) ? -12'sd641 : 12'sd1361;
          2: hum  = 11'd1601 + 11'($urandom_range(0, 446));
          default: co2 = 16'($urandom);
        endcase
        send_item(OP_RECORD, now_ms, now_ms, 1'($urandom), co2, temp, hum, '0);
      end else begin
        send_item(1'($urandom), {$urandom, $urandom},
                  $urandom_range(0, 1) ? longint'({$urandom, $urandom}) & 48'hFFFFFFFFFFFF
                                       : now_ms,
                  1'($urandom), 16'($urandom), 12'($urandom), 11'($urandom), 9'($urandom));
      end
    end
  endtask

  initial begin
    int slow;
    now_ms      = 100000000;
    last_obs    = now_ms;
    bucket_ms   = 300000;
    idling_on   = 1'b1;
    stall_left  = 0;
    cycle_count = 0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: empty read, each rejection reason, range edges, insert.
    send_item(OP_READ, 0, 0, 1'b0, '0, '0, '0, 9'd0);
    send_item(OP_RECORD, now_ms, now_ms, 1'b0, 16'd500, 12'sd0, 11'd0, '0);
    send_item(OP_RECORD, 0, now_ms, 1'b1, 16'd500, 12'sd0, 11'd0, '0);
    send_item(OP_RECORD, now_ms + 300001, now_ms, 1'b1, 16'd500, 12'sd0, 11'd0, '0);
    send_item(OP_RECORD, now_ms - 90000000, now_ms, 1'b1, 16'd500, 12'sd0, 11'd0, '0);
    send_item(OP_RECORD, now_ms, now_ms, 1'b1, 16'd249, 12'sd0, 11'd0, '0);
    send_item(OP_RECORD, now_ms, now_ms, 1'b1, 16'd10001, 12'sd0, 11'd0, '0);
    send_item(OP_RECORD, now_ms, now_ms, 1'b1, 16'hFFFF, -12'sd641, 11'd0, '0);
    send_item(OP_RECORD, now_ms, now_ms, 1'b1, 16'd500, 12'sd1361, 11'd0, '0);
    send_item(OP_RECORD, now_ms, now_ms, 1'b1, 16'd500, 12'sd0, 11'd1601, '0);
    send_item(OP_RECORD, now_ms - 600000, now_ms, 1'b1, 16'd250, -12'sd640, 11'd0, '0);
    send_item(OP_RECORD, now_ms, now_ms, 1'b1, 16'd10000, 12'sd1360, 11'd1600, '0);
    send_item(OP_RECORD, now_ms - 300000, now_ms, 1'b1, 16'd1000, -12'sd1, 11'd2047, '0);
    send_item(OP_RECORD, now_ms - 300000, now_ms, 1'b1, 16'd1000, -12'sd1, 11'd50, '0);
    send_item(OP_RECORD, now_ms + 300000, now_ms, 1'b1, 16'd700, 12'sd300, 11'd800, '0);
    send_item(OP_READ, 0, 0, 1'b0, '0, '0, '0, 9'd0);
    send_item(OP_READ, 0, 0, 1'b0, '0, '0, '0, 9'd3);
    send_item(OP_READ, 0, 0, 1'b0, '0, '0, '0, 9'd511);
    send_item(OP_RECORD, 48'hFFFFFFFFFFFF, 48'hFFFFFFFFFFFF, 1'b1, 16'd800, 12'sd0,
              11'd0, '0);
    send_item(OP_RECORD, 1, 48'hFFFFFFFFFFFF, 1'b1, 16'd800, 12'sd0, 11'd0, '0);
    send_item(OP_READ, 0, 0, 1'b0, '0, '0, '0, 9'd0);

    // Reset settings, a fresh timeline far past the saved time.
    now_ms = 48'hFFFFFFFFFFFF - 64'd5000000000;
    mixed_items(25);

    // Smallest settings.
    write_reg(CFG_BUCKET, 30'd1);
    write_reg(CFG_WINDOW, 30'd1);
    write_reg(CFG_PERSIST, 30'd1);
    write_reg(CFG_MAX, 30'd1);
    mixed_items(10);

    // Fill the table to capacity with spaced buckets, then insert into the full table.
    write_reg(CFG_BUCKET, 30'd1000);
    write_reg(CFG_WINDOW, 30'd604800000);
    write_reg(CFG_PERSIST, 30'd86400000);
    write_reg(CFG_MAX, 30'd512);
    for (int i = 0; i < 514; i++) begin
      now_ms += 2000;
      good_record(now_ms);
    end
    for (int i = 0; i < 2; i++) good_record(now_ms - 1000 - 2000 * $urandom_range(0, 200));
    send_item(OP_READ, 0, 0, 1'b0, '0, '0, '0, 9'd511);
    send_item(OP_READ, 0, 0, 1'b0, '0, '0, '0, 9'd255);

    // Shrink the limit below the held count; the next record trims the excess.
    write_reg(CFG_MAX, 30'd3);
    mixed_items(8);

    // Zero and oversized values, then the largest settings; no idling at the end.
    write_reg(CFG_BUCKET, 30'd0);
    write_reg(CFG_MAX, 30'd0);
    mixed_items(8);
    write_reg(CFG_BUCKET, 30'd3600000);
    write_reg(CFG_WINDOW, 30'h3FFFFFFF);
    write_reg(CFG_PERSIST, 30'h7FFFFFF);
    write_reg(CFG_MAX, 30'h3FF);
    mixed_items(10);
    idling_on = 1'b0;
    mixed_items(10);
    in_valid_i <= 1'b0;

    // Drain, then allow the longest record time before the verdict.
    slow = 0;
    while (pending_count != 0 && slow < 100000) begin
      @(posedge clk_i);
      slow++;
    end
    repeat (2000) @(posedge clk_i);
    if (fail_count == 0 && pending_count == 0) begin
      $display("windowed_sample_history_table_top_tb OK");
    end else begin
      $display("windowed_sample_history_table_top_tb NOT OK");
    end
    $finish;
  end

endmodule

@@ files.f @@
+incdir+rtl
rtl/wsht_pkg.sv
rtl/wsht_div.sv
rtl/wsht_ctrl.sv
rtl/wsht_dp.sv
rtl/windowed_sample_history_table_top.sv
rtl/wsht_checker.sv
bench/windowed_sample_history_table_top_checker.sv
bench/windowed_sample_history_table_top_tb.sv
